>>> design/lobm_pkg.sv
package lobm_pkg;

  localparam int PRICE_LEVELS   = 1024;
  localparam int PRICE_BITS     = $clog2(PRICE_LEVELS);
  localparam int SCAN_BITS      = PRICE_BITS + 1;
  localparam int LEVEL_QTY_BITS = 40;
  localparam int ORDER_QTY_BITS = 32;

  typedef logic [PRICE_BITS-1:0]     price_t;
  typedef logic [SCAN_BITS-1:0]      scan_t;
  typedef logic [LEVEL_QTY_BITS-1:0] qty_t;

  typedef enum logic [0:0] {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_t;

  typedef enum logic [0:0] {
    ALU_SAT_ADD = 1'b0,
    ALU_SUB     = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    qty_t    a;
    qty_t    b;
  } alu_req_t;

  typedef struct packed {
    qty_t y;
    logic borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic   we;
    price_t waddr;
    qty_t   wdata;
    price_t raddr;
  } ram_req_t;

  typedef struct packed {
    logic                      start_new_book;
    side_t                     side;
    logic [ORDER_QTY_BITS-1:0] quantity;
    price_t                    price;
  } order_t;

  typedef struct packed {
    logic   ask_valid;
    price_t ask_price;
    logic   bid_valid;
    price_t bid_price;
    logic   trade_valid;
    price_t trade_price;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_MATCH_CHK,
    ST_MATCH_RD,
    ST_MATCH_SUB,
    ST_SCAN_ASK,
    ST_SCAN_BID,
    ST_DONE
  } state_t;

endpackage

>>> design/lobm_ram.sv
module lobm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 40,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lobm_alu.sv
module lobm_alu import lobm_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic                    is_sub;
  qty_t                    b_op;
  logic [LEVEL_QTY_BITS:0] r;

  always_comb begin
    is_sub = (req.op == ALU_SUB);
    b_op   = is_sub ? ~req.b : req.b;
    r      = {1'b0, req.a} + {1'b0, b_op} + {{LEVEL_QTY_BITS{1'b0}}, is_sub};
    unique case (req.op)
      ALU_SAT_ADD: begin
        rsp.y      = r[LEVEL_QTY_BITS] ? '1 : r[LEVEL_QTY_BITS-1:0];
        rsp.borrow = 1'b0;
      end
      ALU_SUB: begin
        rsp.y      = r[LEVEL_QTY_BITS-1:0];
        rsp.borrow = ~r[LEVEL_QTY_BITS];
      end
      default: begin
        rsp.y      = '0;
        rsp.borrow = 1'b0;
      end
    endcase
  end

endmodule

>>> design/lobm_ctrl.sv
module lobm_ctrl import lobm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  order_t   in_order,
  output logic     res_valid,
  input  logic     res_ready,
  output result_t  res,
  output ram_req_t bid_req,
  output ram_req_t ask_req,
  input  qty_t     bid_rdata,
  input  qty_t     ask_rdata,
  output alu_req_t alu_req,
  input  alu_rsp_t alu_rsp
);

  state_t state, state_next;
  price_t clr_addr, clr_addr_next;
  logic   clr_to_add, clr_to_add_next;
  order_t order, order_next;
  logic   bid_v, bid_v_next;
  price_t bid_lvl, bid_lvl_next;
  logic   ask_v, ask_v_next;
  price_t ask_lvl, ask_lvl_next;
  logic   trade_v, trade_v_next;
  price_t trade_lvl, trade_lvl_next;
  qty_t   aq, aq_next;
  qty_t   bq, bq_next;
  logic   bid_empty, bid_empty_next;
  scan_t  scan_addr, scan_addr_next;
  logic   chk_v, chk_v_next;
  price_t chk_addr, chk_addr_next;
  price_t down_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_to_add <= 1'b0;
      bid_v      <= 1'b0;
      bid_lvl    <= '0;
      ask_v      <= 1'b0;
      ask_lvl    <= '0;
      trade_v    <= 1'b0;
      trade_lvl  <= '0;
      bid_empty  <= 1'b0;
      chk_v      <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      clr_to_add <= clr_to_add_next;
      bid_v      <= bid_v_next;
      bid_lvl    <= bid_lvl_next;
      ask_v      <= ask_v_next;
      ask_lvl    <= ask_lvl_next;
      trade_v    <= trade_v_next;
      trade_lvl  <= trade_lvl_next;
      bid_empty  <= bid_empty_next;
      chk_v      <= chk_v_next;
    end
  end

  always_ff @(posedge clk) begin
    order     <= order_next;
    aq        <= aq_next;
    bq        <= bq_next;
    scan_addr <= scan_addr_next;
    chk_addr  <= chk_addr_next;
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    clr_to_add_next = clr_to_add;
    order_next      = order;
    bid_v_next      = bid_v;
    bid_lvl_next    = bid_lvl;
    ask_v_next      = ask_v;
    ask_lvl_next    = ask_lvl;
    trade_v_next    = trade_v;
    trade_lvl_next  = trade_lvl;
    aq_next         = aq;
    bq_next         = bq;
    bid_empty_next  = bid_empty;
    scan_addr_next  = scan_addr;
    chk_v_next      = chk_v;
    chk_addr_next   = chk_addr;
    down_addr       = price_t'(scan_addr - scan_t'(1));

    in_ready  = 1'b0;
    res_valid = 1'b0;
    bid_req   = '0;
    ask_req   = '0;
    alu_req   = '{op: ALU_SAT_ADD, a: '0, b: '0};

    res.ask_valid   = ask_v;
    res.ask_price   = ask_v ? ask_lvl : '0;
    res.bid_valid   = bid_v;
    res.bid_price   = bid_v ? bid_lvl : '0;
    res.trade_valid = trade_v;
    res.trade_price = trade_v ? trade_lvl : '0;

    unique case (state)
      ST_CLEAR: begin
        bid_req.we    = 1'b1;
        bid_req.waddr = clr_addr;
        ask_req.we    = 1'b1;
        ask_req.waddr = clr_addr;
        bid_v_next    = 1'b0;
        bid_lvl_next  = '0;
        ask_v_next    = 1'b0;
        ask_lvl_next  = '0;
        trade_v_next  = 1'b0;
        trade_lvl_next = '0;
        clr_addr_next = clr_addr + price_t'(1);
        if (clr_addr == price_t'(PRICE_LEVELS - 1)) begin
          state_next = clr_to_add ? ST_ADD_RD : ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          order_next = in_order;
          if (in_order.start_new_book) begin
            clr_addr_next   = '0;
            clr_to_add_next = 1'b1;
            state_next      = ST_CLEAR;
          end else begin
            state_next = ST_ADD_RD;
          end
        end
      end

      ST_ADD_RD: begin
        bid_req.raddr = order.price;
        ask_req.raddr = order.price;
        state_next    = (order.quantity == '0) ? ST_MATCH_CHK : ST_ADD_WR;
      end

      ST_ADD_WR: begin
        alu_req.op = ALU_SAT_ADD;
        alu_req.a  = (order.side == SIDE_SELL) ? ask_rdata : bid_rdata;
        alu_req.b  = qty_t'(order.quantity);
        if (order.side == SIDE_SELL) begin
          ask_req.we    = 1'b1;
          ask_req.waddr = order.price;
          ask_req.wdata = alu_rsp.y;
          if (!ask_v || order.price < ask_lvl) begin
            ask_v_next   = 1'b1;
            ask_lvl_next = order.price;
          end
        end else begin
          bid_req.we    = 1'b1;
          bid_req.waddr = order.price;
          bid_req.wdata = alu_rsp.y;
          if (!bid_v || order.price > bid_lvl) begin
            bid_v_next   = 1'b1;
            bid_lvl_next = order.price;
          end
        end
        state_next = ST_MATCH_CHK;
      end

      ST_MATCH_CHK: begin
        ask_req.raddr = ask_lvl;
        bid_req.raddr = bid_lvl;
        if (bid_v && ask_v && bid_lvl >= ask_lvl) begin
          state_next = ST_MATCH_RD;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_MATCH_RD: begin
        alu_req.op     = ALU_SUB;
        alu_req.a      = ask_rdata;
        alu_req.b      = bid_rdata;
        aq_next        = ask_rdata;
        bq_next        = bid_rdata;
        trade_v_next   = 1'b1;
        trade_lvl_next = ask_lvl;
        if (alu_rsp.borrow) begin
          state_next = ST_MATCH_SUB;
        end else begin
          // bid level fully consumed
          ask_req.we     = 1'b1;
          ask_req.waddr  = ask_lvl;
          ask_req.wdata  = alu_rsp.y;
          bid_req.we     = 1'b1;
          bid_req.waddr  = bid_lvl;
          bid_empty_next = 1'b1;
          chk_v_next     = 1'b0;
          if (alu_rsp.y == '0) begin
            ask_v_next     = 1'b0;
            scan_addr_next = scan_t'(ask_lvl) + scan_t'(1);
            state_next     = ST_SCAN_ASK;
          end else begin
            bid_v_next     = 1'b0;
            scan_addr_next = scan_t'(bid_lvl);
            state_next     = ST_SCAN_BID;
          end
        end
      end

      ST_MATCH_SUB: begin
        // ask level fully consumed
        alu_req.op     = ALU_SUB;
        alu_req.a      = bq;
        alu_req.b      = aq;
        bid_req.we     = 1'b1;
        bid_req.waddr  = bid_lvl;
        bid_req.wdata  = alu_rsp.y;
        ask_req.we     = 1'b1;
        ask_req.waddr  = ask_lvl;
        bid_empty_next = 1'b0;
        chk_v_next     = 1'b0;
        ask_v_next     = 1'b0;
        scan_addr_next = scan_t'(ask_lvl) + scan_t'(1);
        state_next     = ST_SCAN_ASK;
      end

      ST_SCAN_ASK: begin
        ask_req.raddr = scan_addr[PRICE_BITS-1:0];
        if (chk_v && ask_rdata != '0) begin
          ask_v_next   = 1'b1;
          ask_lvl_next = chk_addr;
        end else if (scan_addr < scan_t'(PRICE_LEVELS)) begin
          chk_v_next     = 1'b1;
          chk_addr_next  = scan_addr[PRICE_BITS-1:0];
          scan_addr_next = scan_addr + scan_t'(1);
        end else begin
          ask_lvl_next = '0;
        end
        if ((chk_v && ask_rdata != '0) || !(scan_addr < scan_t'(PRICE_LEVELS))) begin
          chk_v_next = 1'b0;
          if (bid_empty) begin
            bid_v_next     = 1'b0;
            bid_empty_next = 1'b0;
            scan_addr_next = scan_t'(bid_lvl);
            state_next     = ST_SCAN_BID;
          end else begin
            state_next = ST_MATCH_CHK;
          end
        end
      end

      ST_SCAN_BID: begin
        bid_req.raddr = down_addr;
        if (chk_v && bid_rdata != '0) begin
          bid_v_next   = 1'b1;
          bid_lvl_next = chk_addr;
          chk_v_next   = 1'b0;
          state_next   = ST_MATCH_CHK;
        end else if (scan_addr != '0) begin
          chk_v_next     = 1'b1;
          chk_addr_next  = down_addr;
          scan_addr_next = scan_addr - scan_t'(1);
        end else begin
          bid_lvl_next = '0;
          chk_v_next   = 1'b0;
          state_next   = ST_MATCH_CHK;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/limit_order_book_matcher_unit.sv
// Channel | Dir | Beat holds
// s_axis  | in  | tdata: quantity[31:0], price[41:32]; tuser: start_new_book[0], side[1]
// m_axis  | out | tdata: ask_valid, ask_price, bid_valid, bid_price, trade_valid, trade_price
//
// A non-crossing order passes ADD_RD, ADD_WR (none at zero quantity), MATCH_CHK, DONE;
// the next order is taken after DONE. Each trade adds MATCH_RD, and MATCH_SUB if the ask
// level empties first; each rescan reads one level at a time (up to 1023 per side), with
// one adder and one read port per book. start_new_book adds a pass zeroing both books.
// After reset the same pass runs; s_axis_tready stays low until it ends.
// A finished result waits in the output register; the next order is taken meanwhile.
module limit_order_book_matcher_unit import lobm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // quantity[31:0], price[41:32], zero fill
  input  logic [1:0]  s_axis_tuser,   // start_new_book[0], side[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // ask_valid[0], ask_price[10:1], bid_valid[11],
                                      // bid_price[21:12], trade_valid[22],
                                      // trade_price[32:23], zero fill
);

  order_t   in_order;
  result_t  res;
  logic     res_valid;
  logic     res_ready;
  ram_req_t bid_req;
  ram_req_t ask_req;
  qty_t     bid_rdata;
  qty_t     ask_rdata;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign in_order.start_new_book = s_axis_tuser[0];
  assign in_order.side           = side_t'(s_axis_tuser[1]);
  assign in_order.quantity       = s_axis_tdata[ORDER_QTY_BITS-1:0];
  assign in_order.price          = s_axis_tdata[ORDER_QTY_BITS+PRICE_BITS-1:ORDER_QTY_BITS];

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  lobm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_order  (in_order),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .bid_req   (bid_req),
    .ask_req   (ask_req),
    .bid_rdata (bid_rdata),
    .ask_rdata (ask_rdata),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp)
  );

  lobm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  lobm_ram #(.DEPTH(PRICE_LEVELS), .WIDTH(LEVEL_QTY_BITS)) u_bid_ram (
    .clk   (clk),
    .we    (bid_req.we),
    .waddr (bid_req.waddr),
    .wdata (bid_req.wdata),
    .raddr (bid_req.raddr),
    .rdata (bid_rdata)
  );

  lobm_ram #(.DEPTH(PRICE_LEVELS), .WIDTH(LEVEL_QTY_BITS)) u_ask_ram (
    .clk   (clk),
    .we    (ask_req.we),
    .waddr (ask_req.waddr),
    .wdata (ask_req.wdata),
    .raddr (ask_req.raddr),
    .rdata (ask_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {7'b0, res.trade_price, res.trade_valid, res.bid_price,
                       res.bid_valid, res.ask_price, res.ask_valid};
    end
  end

  // one order at a time
  a_one_order: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("order accepted while previous order in work");

  // reported book is never crossed
  a_uncrossed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[11]
      |-> m_axis_tdata[21:12] < m_axis_tdata[10:1])
    else $error("crossed book reported");

  a_trade_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[22] |-> m_axis_tdata[32:23] == 10'd0)
    else $error("trade price nonzero without trade");

endmodule

>>> bench/tb_limit_order_book_matcher_unit.sv
`timescale 1ns / 100ps

module tb_limit_order_book_matcher_unit;
  import lobm_pkg::*;

  // ~1.9k orders, each bounded by a book clear, a full rescan of both sides
  // and its share of fills, all stretched by random stalls, with margin
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     REPORT_MAX  = 10;
  localparam int     TAIL_CYCLES = 2000;
  localparam qty_t   QTY_FULL    = '1;
  localparam logic [ORDER_QTY_BITS-1:0] ORDER_QTY_MAX = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // quantity[31:0], price[41:32], zero fill
  logic [1:0]  s_axis_tuser = '0;   // start_new_book[0], side[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // ask_valid[0], ask_price[10:1], bid_valid[11],
                                    // bid_price[21:12], trade_valid[22],
                                    // trade_price[32:23], zero fill

  limit_order_book_matcher_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // shadow book
  qty_t   bid_qty [PRICE_LEVELS];
  qty_t   ask_qty [PRICE_LEVELS];
  logic   bid_live, ask_live, traded;
  price_t best_bid, best_ask, last_trade;

  result_t expected_books[$];

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     orders_sent    = 0;
  int     results_seen   = 0;
  int     fills_total    = 0;
  int     book_starts    = 0;
  int     zero_orders    = 0;
  int     mismatches     = 0;
  longint cycle_count    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void wipe_book();
    for (int p = 0; p < PRICE_LEVELS; p++) begin
      bid_qty[p] = '0;
      ask_qty[p] = '0;
    end
    bid_live   = 1'b0;
    ask_live   = 1'b0;
    traded     = 1'b0;
    best_bid   = '0;
    best_ask   = '0;
    last_trade = '0;
  endfunction

  function automatic result_t apply_order(input logic start, input side_t side,
                                          input logic [ORDER_QTY_BITS-1:0] qty,
                                          input price_t price);
    logic [LEVEL_QTY_BITS:0] sum;
    qty_t    aq, bq, fill;
    int      a, b;
    result_t r;
    if (start)
      wipe_book();
    if (qty != 0) begin
      if (side == SIDE_BUY) begin
        sum = {1'b0, bid_qty[price]} + qty;
        bid_qty[price] = sum[LEVEL_QTY_BITS] ? QTY_FULL : sum[LEVEL_QTY_BITS-1:0];
        if (!bid_live || price > best_bid) begin
          bid_live = 1'b1;
          best_bid = price;
        end
      end else begin
        sum = {1'b0, ask_qty[price]} + qty;
        ask_qty[price] = sum[LEVEL_QTY_BITS] ? QTY_FULL : sum[LEVEL_QTY_BITS-1:0];
        if (!ask_live || price < best_ask) begin
          ask_live = 1'b1;
          best_ask = price;
        end
      end
    end
    while (bid_live && ask_live && best_bid >= best_ask) begin
      a    = best_ask;
      b    = best_bid;
      aq   = ask_qty[a];
      bq   = bid_qty[b];
      fill = (aq < bq) ? aq : bq;
      last_trade = best_ask;
      traded     = 1'b1;
      fills_total++;
      ask_qty[a] = aq - fill;
      bid_qty[b] = bq - fill;
      if (ask_qty[a] == 0) begin
        ask_live = 1'b0;
        best_ask = '0;
        for (int p = a + 1; p < PRICE_LEVELS && !ask_live; p++)
          if (ask_qty[p] != 0) begin
            ask_live = 1'b1;
            best_ask = price_t'(p);
          end
      end
      if (bid_qty[b] == 0) begin
        bid_live = 1'b0;
        best_bid = '0;
        for (int p = b - 1; p >= 0 && !bid_live; p--)
          if (bid_qty[p] != 0) begin
            bid_live = 1'b1;
            best_bid = price_t'(p);
          end
      end
    end
    r.ask_valid   = ask_live;
    r.ask_price   = ask_live ? best_ask : '0;
    r.bid_valid   = bid_live;
    r.bid_price   = bid_live ? best_bid : '0;
    r.trade_valid = traded;
    r.trade_price = traded ? last_trade : '0;
    return r;
  endfunction

  task automatic send_order(input logic start, input side_t side,
                            input logic [ORDER_QTY_BITS-1:0] qty, input price_t price);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, price, qty};
    s_axis_tuser  <= {side, start};
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    expected_books.push_back(apply_order(start, side, qty, price));
    orders_sent++;
    if (start)
      book_starts++;
    if (qty == 0)
      zero_orders++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_books.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    result_t got, want;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ask_valid   = m_axis_tdata[0];
      got.ask_price   = m_axis_tdata[10:1];
      got.bid_valid   = m_axis_tdata[11];
      got.bid_price   = m_axis_tdata[21:12];
      got.trade_valid = m_axis_tdata[22];
      got.trade_price = m_axis_tdata[32:23];
      results_seen++;
      if (expected_books.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result %0d arrived with no order pending: %h",
                   $realtime, results_seen, m_axis_tdata);
      end else begin
        want = expected_books.pop_front();
        if (got.ask_valid !== want.ask_valid || got.ask_price !== want.ask_price ||
            got.bid_valid !== want.bid_valid || got.bid_price !== want.bid_price ||
            got.trade_valid !== want.trade_valid ||
            got.trade_price !== want.trade_price) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"[%0t] result %0d: expected ask %b/%0d bid %b/%0d trade %b/%0d,",
                      " got ask %b/%0d bid %b/%0d trade %b/%0d"},
                     $realtime, results_seen,
                     want.ask_valid, want.ask_price, want.bid_valid, want.bid_price,
                     want.trade_valid, want.trade_price,
                     got.ask_valid, got.ask_price, got.bid_valid, got.bid_price,
                     got.trade_valid, got.trade_price);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** limit_order_book_matcher_unit: FAILED **");
    $finish;
  end

  // extremes of every field, crossing at both book edges, sweeps, new books
  task automatic test_directed();
    send_order(1'b1, SIDE_BUY,  32'd1,         10'd0);
    send_order(1'b0, SIDE_SELL, ORDER_QTY_MAX, 10'd1023);
    send_order(1'b0, SIDE_BUY,  32'd5,         10'd1023);
    send_order(1'b0, SIDE_SELL, 32'd1,         10'd0);
    send_order(1'b0, SIDE_BUY,  32'd0,         10'd512);
    send_order(1'b0, SIDE_SELL, 32'd0,         10'd1);
    send_order(1'b1, SIDE_SELL, 32'd0,         10'd1023);
    send_order(1'b0, SIDE_SELL, 32'd10,        10'd500);
    send_order(1'b0, SIDE_BUY,  32'd3,         10'd600);
    send_order(1'b0, SIDE_BUY,  32'd7,         10'd600);
    send_order(1'b0, SIDE_SELL, 32'd2,         10'h155);
    send_order(1'b0, SIDE_SELL, 32'd2,         10'h156);
    send_order(1'b0, SIDE_SELL, 32'd2,         10'h157);
    send_order(1'b0, SIDE_BUY,  32'd7,         10'h2AA);
    send_order(1'b0, SIDE_SELL, 32'd1,         10'h2AA);
    send_order(1'b0, SIDE_BUY,  32'h8000_0000, 10'd10);
    send_order(1'b0, SIDE_BUY,  32'h5555_5555, 10'd9);
    send_order(1'b0, SIDE_SELL, 32'hAAAA_AAAA, 10'd9);
    send_order(1'b1, SIDE_BUY,  32'd3,         10'd7);
    send_order(1'b0, SIDE_SELL, 32'd3,         10'd8);
    send_order(1'b0, SIDE_BUY,  32'd1,         10'd8);
    send_order(1'b0, SIDE_SELL, ORDER_QTY_MAX, 10'd7);
    wait_drained();
  endtask

  // 257 maximum orders pin one level at full scale; the other side then
  // takes exactly what a saturated level holds
  task automatic test_level_saturation();
    side_t fill_side, take_side;
    for (int s = 0; s < 2; s++) begin
      fill_side = side_t'(s);
      take_side = side_t'(1 - s);
      send_order(1'b1, fill_side, ORDER_QTY_MAX, 10'd300);
      repeat (256) send_order(1'b0, fill_side, ORDER_QTY_MAX, 10'd300);
      repeat (256) send_order(1'b0, take_side, ORDER_QTY_MAX, 10'd300);
      send_order(1'b0, take_side, 32'd255, 10'd300);
      send_order(1'b0, take_side, 32'd1,   10'd300);
    end
    wait_drained();
  endtask

  // orders clustered around a drifting mid price so they cross often,
  // with stray far levels, large sizes and occasional fresh books
  task automatic random_orders(input int count);
    int    mid, pick, pr;
    logic  start;
    side_t side;
    logic [ORDER_QTY_BITS-1:0] qty;
    mid = $urandom_range(40, 980);
    repeat (count) begin
      start = ($urandom_range(149) == 0);
      side  = side_t'($urandom_range(1));
      pick  = $urandom_range(99);
      if (pick < 60)
        qty = $urandom_range(1, 200);
      else if (pick < 80)
        qty = $urandom_range(1, 65535);
      else if (pick < 93)
        qty = $urandom() | 32'd1 << $urandom_range(31);
      else if (pick < 98)
        qty = ORDER_QTY_MAX;
      else
        qty = '0;
      pick = $urandom_range(99);
      if (pick < 86)
        pr = mid + $urandom_range(0, 16) - 8;
      else if (pick < 96)
        pr = $urandom_range(0, PRICE_LEVELS - 1);
      else
        pr = $urandom_range(1) ? PRICE_LEVELS - 1 : 0;
      if (pr < 0)
        pr = 0;
      if (pr > PRICE_LEVELS - 1)
        pr = PRICE_LEVELS - 1;
      if ($urandom_range(31) == 0) begin
        mid = mid + $urandom_range(0, 40) - 20;
        if (mid < 10)
          mid = 10;
        if (mid > 1013)
          mid = 1013;
      end
      send_order(start, side, qty, price_t'(pr));
    end
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    random_orders(205);
    wait_drained();
    set_idling(72, 0);
    random_orders(205);
    wait_drained();
    set_idling(0, 72);
    random_orders(205);
    wait_drained();
    set_idling(34, 34);
    random_orders(205);
  endtask

  initial begin
    wipe_book();
    @(posedge clk);
    while (rst)
      @(posedge clk);
    test_directed();
    test_level_saturation();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += expected_books.size();
    $display("Sent %0d orders (directed, saturated levels on both sides, four stall mixes);",
             orders_sent);
    $display("checked %0d books, %0d fills, %0d new-book starts, %0d zero-size orders.",
             results_seen, fills_total, book_starts, zero_orders);
    if (mismatches == 0)
      $display("** limit_order_book_matcher_unit: PASSED **");
    else
      $display("** limit_order_book_matcher_unit: FAILED **");
    $finish;
  end

endmodule
